>>> src/dlst_pkg.sv
// Shared widths, constants and types for the decimal list sum block.
package dlst_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned SUM_W   = 25;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned CFG_W   = 25;
  localparam int unsigned CFG_IDX_W = 1;

  // Hard ceiling on values taken from one line, on top of count_limit.
  localparam logic [CNT_W-1:0] MAX_VALUES = 10'd512;

  localparam logic [SUM_W-1:0] THRESHOLD_RESET = 25'd6993;
  localparam logic [CNT_W-1:0] LIMIT_RESET     = 10'd400;

  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

  localparam logic [CFG_IDX_W-1:0] REG_DENSE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT     = 1'd1;

  typedef struct packed {
    logic [VALUE_W-1:0] value_accum;
    logic               in_number;
    logic [CNT_W-1:0]   values_seen;
    logic [SUM_W-1:0]   running_sum;
    logic               line_has_bytes;
  } line_state_t;

  typedef struct packed {
    logic [SUM_W-1:0] score;
    logic             dense;
    logic [CNT_W-1:0] value_count;
    logic             no_values;
  } line_result_t;

endpackage

>>> src/dlst_step.sv
// Next-state and result logic for one text byte of the line parser.
module dlst_step (
  input  dlst_pkg::line_state_t            cur_state,
  input  logic [dlst_pkg::CHAR_W-1:0]      char_byte,
  input  logic [dlst_pkg::SUM_W-1:0]       dense_threshold,
  input  logic [dlst_pkg::CNT_W-1:0]       count_limit,
  output dlst_pkg::line_state_t            nxt_state,
  output dlst_pkg::line_result_t           result,
  output logic                             emit
);

  logic                            is_eol;
  logic                            is_digit;
  logic [dlst_pkg::CNT_W-1:0]      lim_eff;
  logic                            take;
  logic [dlst_pkg::VALUE_W+3:0]    scaled;
  logic [dlst_pkg::VALUE_W-1:0]    digit_value;
  logic [dlst_pkg::SUM_W:0]        sum_wide;
  logic [dlst_pkg::SUM_W-1:0]      sum_fin;
  logic [dlst_pkg::CNT_W-1:0]      seen_fin;

  always_comb begin
    is_eol   = (char_byte == dlst_pkg::CHAR_CR) || (char_byte == dlst_pkg::CHAR_LF);
    is_digit = (char_byte >= dlst_pkg::CHAR_ZERO) && (char_byte <= dlst_pkg::CHAR_NINE);
    lim_eff  = (count_limit > dlst_pkg::MAX_VALUES) ? dlst_pkg::MAX_VALUES : count_limit;

    // accum * 10 + digit, saturated at the 16-bit maximum.
    scaled = ({4'd0, cur_state.value_accum} << 3) + ({4'd0, cur_state.value_accum} << 1)
           + {16'd0, char_byte[3:0]};
    digit_value = (|scaled[dlst_pkg::VALUE_W+3:dlst_pkg::VALUE_W]) ? '1
                                                                    : scaled[dlst_pkg::VALUE_W-1:0];

    // Closing the current value, if one is open and the limit allows it.
    take     = cur_state.in_number && (cur_state.values_seen < lim_eff);
    sum_wide = {1'b0, cur_state.running_sum} + {9'd0, cur_state.value_accum};
    sum_fin  = cur_state.running_sum;
    seen_fin = cur_state.values_seen;
    if (take) begin
      sum_fin  = sum_wide[dlst_pkg::SUM_W] ? '1 : sum_wide[dlst_pkg::SUM_W-1:0];
      seen_fin = cur_state.values_seen + 10'd1;
    end

    nxt_state = cur_state;
    emit      = 1'b0;
    result    = '0;

    if (is_eol) begin
      emit      = cur_state.line_has_bytes;
      nxt_state = '0;
      if (seen_fin == '0) begin
        result.no_values = 1'b1;
      end else begin
        result.score       = sum_fin;
        result.dense       = (sum_fin >= dense_threshold);
        result.value_count = seen_fin;
      end
    end else if (is_digit) begin
      nxt_state.value_accum    = digit_value;
      nxt_state.in_number      = 1'b1;
      nxt_state.line_has_bytes = 1'b1;
    end else begin
      nxt_state.value_accum    = '0;
      nxt_state.in_number      = 1'b0;
      nxt_state.values_seen    = seen_fin;
      nxt_state.running_sum    = sum_fin;
      nxt_state.line_has_bytes = 1'b1;
    end
  end

endmodule

>>> src/decimal_list_sum_threshold.sv
// Top level of the decimal list sum block: input register, line state and result register.
//
// Usage: text arrives one byte per transaction on the in_ channel (in_valid, in_ready,
// in_char_byte). Digit runs form values that saturate at 65535; any other byte except
// CR and LF separates them. Values are summed until min(count_limit, 512) have been
// taken. A CR or LF ending a non-empty line produces one transaction on the out_
// channel with out_score, out_dense, out_value_count and out_no_values; an empty line
// produces nothing, so a CR LF pair yields a single result.
// The cfg_ port writes dense_threshold (index 0) or count_limit (index 1), as cfg_index
// selects, whenever cfg_we is high; it is meant to be used only while the block is idle.
// Throughput is one byte per cycle while results are taken. Each byte is first captured in
// an input register; the combinational update of the line state then loads the line state
// and, for a line-ending byte, the result register, from which the result is offered.
// Synchronous reset clears the line state and the valid flags of both pipeline stages
// and restores the register defaults (6993 and 400). When the receiver stalls, the result
// register holds its transaction; the input register takes at most one more byte, after
// which in_ready drops until out_ready returns.
module decimal_list_sum_threshold (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dlst_pkg::CHAR_W-1:0]          in_char_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dlst_pkg::SUM_W-1:0]           out_score,
  output logic                                 out_dense,
  output logic [dlst_pkg::CNT_W-1:0]           out_value_count,
  output logic                                 out_no_values,
  input  logic                                 cfg_we,
  input  logic [dlst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dlst_pkg::CFG_W-1:0]           cfg_data
);

  // Configuration registers.
  logic [dlst_pkg::SUM_W-1:0] thr_r;
  logic [dlst_pkg::CNT_W-1:0] lim_r;

  // Input stage.
  logic                        s1_valid_r;
  logic [dlst_pkg::CHAR_W-1:0] s1_byte_r;

  // Line state and result stage.
  dlst_pkg::line_state_t  st_r;
  dlst_pkg::line_state_t  st_nxt;
  dlst_pkg::line_result_t res_nxt;
  dlst_pkg::line_result_t res_r;
  logic                   emit;
  logic                   out_valid_r;
  logic                   advance;

  // The input stage moves on whenever the result register is free or being drained.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;

  dlst_step u_step (
    .cur_state       (st_r),
    .char_byte       (s1_byte_r),
    .dense_threshold (thr_r),
    .count_limit     (lim_r),
    .nxt_state       (st_nxt),
    .result          (res_nxt),
    .emit            (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= dlst_pkg::THRESHOLD_RESET;
      lim_r <= dlst_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlst_pkg::REG_DENSE_THRESHOLD: thr_r <= cfg_data[dlst_pkg::SUM_W-1:0];
        dlst_pkg::REG_COUNT_LIMIT:     lim_r <= cfg_data[dlst_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_score       = res_r.score;
  assign out_dense       = res_r.dense;
  assign out_value_count = res_r.value_count;
  assign out_no_values   = res_r.no_values;

endmodule

>>> src/dlst_checker.sv
// Port-level checks for the decimal list sum block, bound to its top level.
module dlst_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dlst_pkg::SUM_W-1:0]  out_score,
  input logic                        out_dense,
  input logic [dlst_pkg::CNT_W-1:0]  out_value_count,
  input logic                        out_no_values
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score) && $stable(out_dense)
      && $stable(out_value_count) && $stable(out_no_values))
    else $error("result changed while stalled");

  // A line without values reports an all-zero result.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_values |-> out_score == '0 && !out_dense && out_value_count == '0)
    else $error("no-values result carries data");

  // A line with values counts at least one and never more than the ceiling.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_no_values |-> out_value_count != '0
      && out_value_count <= dlst_pkg::MAX_VALUES)
    else $error("value count out of range");

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind decimal_list_sum_threshold dlst_checker u_dlst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_score       (out_score),
  .out_dense       (out_dense),
  .out_value_count (out_value_count),
  .out_no_values   (out_no_values)
);
